[hdl/pou_pkg.sv]
package pou_pkg;

   // grid layout and side limits
   localparam int GRID_STRIDE = 8;
   localparam int GRID_BITS   = GRID_STRIDE * GRID_STRIDE;
   localparam int SIDE_W      = 4;
   localparam int MAX_SIDE    = 8;
   localparam int NUM_ORIENT  = 8;
   localparam int IDX_W       = 3;
   localparam int SHIFT_W     = 6;

   // orientation codes, order of the derived copies of one shape
   localparam logic [IDX_W-1:0] OR_BASE = 3'd0;  // shape as given
   localparam logic [IDX_W-1:0] OR_CW   = 3'd1;  // one quarter turn clockwise
   localparam logic [IDX_W-1:0] OR_HALF = 3'd2;  // half turn
   localparam logic [IDX_W-1:0] OR_CCW  = 3'd3;  // three quarter turns
   localparam logic [IDX_W-1:0] OR_MIR  = 3'd4;  // horizontal mirror
   localparam logic [IDX_W-1:0] OR_MCW  = 3'd5;  // mirror, one quarter turn
   localparam logic [IDX_W-1:0] OR_MHF  = 3'd6;  // mirror, half turn
   localparam logic [IDX_W-1:0] OR_MCCW = 3'd7;  // mirror, three quarter turns

   typedef struct packed {
      logic [GRID_BITS-1:0] cells;
      logic [SIDE_W-1:0]    cols;
      logic [SIDE_W-1:0]    rows;
   } orient_type;

   typedef orient_type [NUM_ORIENT-1:0] orient_set_type;

   // number of plain turns (1, 2 or 4) and total orientations (1..8)
   typedef struct packed {
      logic [IDX_W-1:0]  n_plain;
      logic [SIDE_W-1:0] n_total;
   } count_type;

   // fixed 8x8 permutation for one orientation code, pure wiring
   function automatic logic [GRID_BITS-1:0] fixed_map(logic [GRID_BITS-1:0] g,
                                                      logic [IDX_W-1:0] kind);
      logic [GRID_BITS-1:0] res;
      logic [2:0] r3;
      logic [2:0] c3;
      logic [2:0] dr;
      logic [2:0] dc;
      res = '0;
      for (int r = 0; r < GRID_STRIDE; r++) begin
         for (int c = 0; c < GRID_STRIDE; c++) begin
            r3 = 3'(r);
            c3 = 3'(c);
            case (kind)
               OR_BASE: begin dr = r3;    dc = c3;    end
               OR_CW:   begin dr = c3;    dc = ~r3;   end
               OR_HALF: begin dr = ~r3;   dc = ~c3;   end
               OR_CCW:  begin dr = ~c3;   dc = r3;    end
               OR_MIR:  begin dr = r3;    dc = ~c3;   end
               OR_MCW:  begin dr = ~c3;   dc = ~r3;   end
               OR_MHF:  begin dr = ~r3;   dc = c3;    end
               default: begin dr = c3;    dc = r3;    end
            endcase
            res[{dr, dc}] = g[{r3, c3}];
         end
      end
      return res;
   endfunction

   // shift that pulls the fixed-mapped shape back to the top left corner
   function automatic logic [SHIFT_W-1:0] align_shift(logic [IDX_W-1:0] kind,
                                                      logic [SIDE_W-1:0] w,
                                                      logic [SIDE_W-1:0] h);
      logic [SIDE_W-1:0] wg;
      logic [SIDE_W-1:0] hg;
      logic [2:0] w8;
      logic [2:0] h8;
      logic [SHIFT_W-1:0] res;
      wg = SIDE_W'(GRID_STRIDE) - w;
      hg = SIDE_W'(GRID_STRIDE) - h;
      w8 = wg[2:0];
      h8 = hg[2:0];
      case (kind)
         OR_BASE: res = {3'd0, 3'd0};
         OR_CW:   res = {3'd0, h8};
         OR_HALF: res = {h8, w8};
         OR_CCW:  res = {w8, 3'd0};
         OR_MIR:  res = {3'd0, w8};
         OR_MCW:  res = {w8, h8};
         OR_MHF:  res = {h8, 3'd0};
         default: res = {3'd0, 3'd0};
      endcase
      return res;
   endfunction

   // codes whose width and height are swapped
   function automatic logic dims_swapped(logic [IDX_W-1:0] kind);
      return kind[0];
   endfunction

   function automatic logic same(orient_type a, orient_type b);
      return (a.cols == b.cols) && (a.rows == b.rows) && (a.cells == b.cells);
   endfunction

endpackage

[hdl/pou_prep.sv]
module pou_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_stall,
   input  logic [pou_pkg::GRID_BITS-1:0] up_grid,
   input  logic [pou_pkg::SIDE_W-1:0]    up_cols,
   input  logic [pou_pkg::SIDE_W-1:0]    up_rows,
   output logic                         dn_valid,
   input  logic                         dn_stall,
   output pou_pkg::orient_type          dn_shape
);
   import pou_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   orient_type shape_ff;
   orient_type shape_in;
   logic       load;
   logic [SIDE_W-1:0] w;
   logic [SIDE_W-1:0] h;
   logic [GRID_BITS-1:0] mask;

   // clamp the size into 1..max side
   always_comb begin
      if (up_cols == '0) w = SIDE_W'(1);
      else if (up_cols > SIDE_W'(MAX_SIDE)) w = SIDE_W'(MAX_SIDE);
      else w = up_cols;
      if (up_rows == '0) h = SIDE_W'(1);
      else if (up_rows > SIDE_W'(MAX_SIDE)) h = SIDE_W'(MAX_SIDE);
      else h = up_rows;
   end

   // cells inside the corrected size
   always_comb begin
      mask = '0;
      for (int r = 0; r < GRID_STRIDE; r++) begin
         for (int c = 0; c < GRID_STRIDE; c++) begin
            mask[r*GRID_STRIDE + c] = (SIDE_W'(r) < h) && (SIDE_W'(c) < w);
         end
      end
   end

   assign up_stall = valid_ff && dn_stall;
   assign load     = !up_stall;

   always_comb begin
      valid_in = valid_ff;
      shape_in = shape_ff;
      if (load) begin
         valid_in       = up_valid;
         shape_in.cells = up_grid & mask;
         shape_in.cols  = w;
         shape_in.rows  = h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      shape_ff <= shape_in;
   end

   assign dn_valid = valid_ff;
   assign dn_shape = shape_ff;

endmodule

[hdl/pou_xform.sv]
module pou_xform (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  pou_pkg::orient_type     up_shape,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output pou_pkg::orient_set_type dn_set
);
   import pou_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   orient_set_type set_ff;
   orient_set_type set_in;
   orient_set_type set_calc;
   logic           load;

   // all eight orientations: fixed permutation then a realigning shift
   always_comb begin
      for (int k = 0; k < NUM_ORIENT; k++) begin
         set_calc[k].cells = fixed_map(up_shape.cells, IDX_W'(k))
                             >> align_shift(IDX_W'(k), up_shape.cols, up_shape.rows);
         if (dims_swapped(IDX_W'(k))) begin
            set_calc[k].cols = up_shape.rows;
            set_calc[k].rows = up_shape.cols;
         end else begin
            set_calc[k].cols = up_shape.cols;
            set_calc[k].rows = up_shape.rows;
         end
      end
   end

   assign up_stall = valid_ff && dn_stall;
   assign load     = !up_stall;

   always_comb begin
      valid_in = valid_ff;
      set_in   = set_ff;
      if (load) begin
         valid_in = up_valid;
         set_in   = set_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      set_ff <= set_in;
   end

   assign dn_valid = valid_ff;
   assign dn_set   = set_ff;

endmodule

[hdl/pou_match.sv]
module pou_match (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  pou_pkg::orient_set_type up_set,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output pou_pkg::orient_set_type dn_set,
   output pou_pkg::count_type      dn_count
);
   import pou_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   orient_set_type set_ff;
   orient_set_type set_in;
   count_type      count_ff;
   count_type      count_in;
   count_type      count_calc;
   logic           load;
   logic           eq_cw;
   logic           eq_half;
   logic           dup;

   // symmetry checks: turn period and whether the mirror is already a turn
   always_comb begin
      eq_cw   = same(up_set[OR_CW], up_set[OR_BASE]);
      eq_half = same(up_set[OR_HALF], up_set[OR_BASE]);
      dup     = same(up_set[OR_MIR], up_set[OR_BASE]) ||
                same(up_set[OR_MIR], up_set[OR_CW]) ||
                same(up_set[OR_MIR], up_set[OR_HALF]) ||
                same(up_set[OR_MIR], up_set[OR_CCW]);
      if (eq_cw) count_calc.n_plain = IDX_W'(1);
      else if (eq_half) count_calc.n_plain = IDX_W'(2);
      else count_calc.n_plain = IDX_W'(4);
      // mirrored turns share the period of the plain turns
      if (dup) count_calc.n_total = SIDE_W'(count_calc.n_plain);
      else count_calc.n_total = {count_calc.n_plain, 1'b0};
   end

   assign up_stall = valid_ff && dn_stall;
   assign load     = !up_stall;

   always_comb begin
      valid_in = valid_ff;
      set_in   = set_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = up_valid;
         set_in   = up_set;
         count_in = count_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      set_ff   <= set_in;
      count_ff <= count_in;
   end

   assign dn_valid = valid_ff;
   assign dn_set   = set_ff;
   assign dn_count = count_ff;

endmodule

[hdl/pou_emit.sv]
module pou_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_stall,
   input  pou_pkg::orient_set_type       up_set,
   input  pou_pkg::count_type            up_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pou_pkg::GRID_BITS-1:0] rsp_out_grid,
   output logic [pou_pkg::SIDE_W-1:0]    rsp_out_cols,
   output logic [pou_pkg::SIDE_W-1:0]    rsp_out_rows,
   output logic                          rsp_mirrored,
   output logic                          rsp_last
);
   import pou_pkg::*;

   // holding stage: one shape's orientations, walked by an index
   logic           hold_valid_ff;
   logic           hold_valid_in;
   orient_set_type hold_set_ff;
   orient_set_type hold_set_in;
   count_type      hold_count_ff;
   count_type      hold_count_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   // output register
   logic           out_valid_ff;
   logic           out_valid_in;
   orient_type     out_orient_ff;
   orient_type     out_orient_in;
   logic           out_mirrored_ff;
   logic           out_mirrored_in;
   logic           out_last_ff;
   logic           out_last_in;

   logic             adv;
   logic             take;
   logic             is_last;
   logic             is_mirror;
   logic [IDX_W-1:0] sel;

   assign adv       = hold_valid_ff && (!out_valid_ff || !rsp_stall);
   assign is_last   = ({1'b0, idx_ff} + SIDE_W'(1)) == hold_count_ff.n_total;
   assign take      = !hold_valid_ff || (adv && is_last);
   assign up_stall  = up_valid && !take;
   assign is_mirror = idx_ff >= hold_count_ff.n_plain;

   // plain turns first, then mirrored turns starting at the mirror code
   assign sel = is_mirror ? (idx_ff - hold_count_ff.n_plain + OR_MIR) : idx_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_set_in   = hold_set_ff;
      hold_count_in = hold_count_ff;
      idx_in        = idx_ff;
      if (take) begin
         hold_valid_in = up_valid;
         hold_set_in   = up_set;
         hold_count_in = up_count;
         idx_in        = '0;
      end else if (adv) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_orient_in   = out_orient_ff;
      out_mirrored_in = out_mirrored_ff;
      out_last_in     = out_last_ff;
      if (adv) begin
         out_valid_in    = 1'b1;
         out_orient_in   = hold_set_ff[sel];
         out_mirrored_in = is_mirror;
         out_last_in     = is_last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_set_ff     <= hold_set_in;
      hold_count_ff   <= hold_count_in;
      idx_ff          <= idx_in;
      out_orient_ff   <= out_orient_in;
      out_mirrored_ff <= out_mirrored_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_grid = out_orient_ff.cells;
   assign rsp_out_cols = out_orient_ff.cols;
   assign rsp_out_rows = out_orient_ff.rows;
   assign rsp_mirrored = out_mirrored_ff;
   assign rsp_last     = out_last_ff;

endmodule

[hdl/polyomino_orientations_unit.sv]
// polyomino orientation generator
// request channel: one shape per item, an 8x8 bitmap (cell at row*8+col) with
// its width and height; sizes of zero are taken as one, above eight as eight,
// and cells outside the size are ignored.
// response channel: the shape's distinct fixed orientations, one item per
// cycle: the shape and its clockwise quarter turns up to the first repeat,
// then, if the mirror image is new, the mirror and its turns. mirrored marks
// items from the mirror image, last marks the final item of the shape.
// both channels: an item moves on a clock edge with valid high and stall low.
// a request item passes the clamp/mask, transform, compare and hold stages,
// then the output register, before its first orientation shows on rsp_.
// throughput: one response item per cycle while rsp_stall is low, so a shape
// takes as many items as it has orientations; shapes follow one another
// without a gap when the next one is ready.
// reset (synchronous, active high) empties every stage; no item is in flight.
// a stall on rsp_ holds the output item and backs up through the stages to
// req_stall; nothing is dropped or repeated.
module polyomino_orientations_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pou_pkg::GRID_BITS-1:0] req_grid,
   input  logic [pou_pkg::SIDE_W-1:0]    req_cols,
   input  logic [pou_pkg::SIDE_W-1:0]    req_rows_used,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pou_pkg::GRID_BITS-1:0] rsp_out_grid,
   output logic [pou_pkg::SIDE_W-1:0]    rsp_out_cols,
   output logic [pou_pkg::SIDE_W-1:0]    rsp_out_rows,
   output logic                          rsp_mirrored,
   output logic                          rsp_last
);
   import pou_pkg::*;

   logic           s1_valid;
   logic           s1_stall;
   orient_type     s1_shape;
   logic           s2_valid;
   logic           s2_stall;
   orient_set_type s2_set;
   logic           s3_valid;
   logic           s3_stall;
   orient_set_type s3_set;
   count_type      s3_count;

   // clamp size and mask stray cells
   pou_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_grid  (req_grid),
      .up_cols  (req_cols),
      .up_rows  (req_rows_used),
      .dn_valid (s1_valid),
      .dn_stall (s1_stall),
      .dn_shape (s1_shape)
   );

   // build all eight orientations
   pou_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_stall (s1_stall),
      .up_shape (s1_shape),
      .dn_valid (s2_valid),
      .dn_stall (s2_stall),
      .dn_set   (s2_set)
   );

   // find the symmetry and the orientation counts
   pou_match u_match (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_stall (s2_stall),
      .up_set   (s2_set),
      .dn_valid (s3_valid),
      .dn_stall (s3_stall),
      .dn_set   (s3_set),
      .dn_count (s3_count)
   );

   // serialize the distinct orientations
   pou_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (s3_valid),
      .up_stall     (s3_stall),
      .up_set       (s3_set),
      .up_count     (s3_count),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_grid (rsp_out_grid),
      .rsp_out_cols (rsp_out_cols),
      .rsp_out_rows (rsp_out_rows),
      .rsp_mirrored (rsp_mirrored),
      .rsp_last     (rsp_last)
   );

endmodule
